// ===== rtl/core/hswf_pkg.sv =====
// Shared types and constants for the haptic square wall force unit.
`timescale 1ns / 1ps

package hswf_pkg;

	localparam int HALF_SIZE_W   = 23;
	localparam int STIFFNESS_W   = 24;
	localparam int FORCE_LIMIT_W = 26;
	localparam int FORCE_W       = 27;
	localparam int STIFF_FRAC_W  = 8;
	localparam int CFG_INDEX_W   = 3;

	localparam logic [CFG_INDEX_W-1:0] REG_HALF_SIZE   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_STIFFNESS   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FORCE_LIMIT = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Z    = 3'd5;

	localparam logic [HALF_SIZE_W-1:0]   HALF_SIZE_RST   = 23'd50000;
	localparam logic [STIFFNESS_W-1:0]   STIFFNESS_RST   = 24'd64000;
	localparam logic [FORCE_LIMIT_W-1:0] FORCE_LIMIT_RST = 26'd5000000;

	// per-item flags carried from the geometry stage to the force stage
	typedef struct packed {
		logic pose_valid;
		logic dy_pos;
		logic dy_neg;
	} geom_flags_t;

endpackage

// ===== rtl/core/hswf_cfg_regs.sv =====
// Configuration register file for the square wall geometry and stiffness.
`timescale 1ns / 1ps

module hswf_cfg_regs
	import hswf_pkg::*;
#(
	parameter int POSITION_BITS = 24,
	parameter int CFG_DATA_W    = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_INDEX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	output logic [HALF_SIZE_W-1:0]        half_size,
	output logic [STIFFNESS_W-1:0]        stiffness,
	output logic [FORCE_LIMIT_W-1:0]      force_limit,
	output logic signed [POSITION_BITS-1:0] center_x,
	output logic signed [POSITION_BITS-1:0] center_y,
	output logic signed [POSITION_BITS-1:0] center_z
);

	logic [HALF_SIZE_W-1:0]   half_size_q;
	logic [STIFFNESS_W-1:0]   stiffness_q;
	logic [FORCE_LIMIT_W-1:0] force_limit_q;
	logic [POSITION_BITS-1:0] center_x_q;
	logic [POSITION_BITS-1:0] center_y_q;
	logic [POSITION_BITS-1:0] center_z_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_size_q   <= HALF_SIZE_RST;
			stiffness_q   <= STIFFNESS_RST;
			force_limit_q <= FORCE_LIMIT_RST;
			center_x_q    <= '0;
			center_y_q    <= '0;
			center_z_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_HALF_SIZE:   half_size_q   <= cfg_data[HALF_SIZE_W-1:0];
				REG_STIFFNESS:   stiffness_q   <= cfg_data[STIFFNESS_W-1:0];
				REG_FORCE_LIMIT: force_limit_q <= cfg_data[FORCE_LIMIT_W-1:0];
				REG_CENTER_X:    center_x_q    <= cfg_data[POSITION_BITS-1:0];
				REG_CENTER_Y:    center_y_q    <= cfg_data[POSITION_BITS-1:0];
				REG_CENTER_Z:    center_z_q    <= cfg_data[POSITION_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign half_size   = half_size_q;
	assign stiffness   = stiffness_q;
	assign force_limit = force_limit_q;
	assign center_x    = signed'(center_x_q);
	assign center_y    = signed'(center_y_q);
	assign center_z    = signed'(center_z_q);

endmodule

// ===== rtl/core/hswf_geom.sv =====
// Input stage: tip offsets from the square center, registered as magnitudes and flags.
`timescale 1ns / 1ps

module hswf_geom
	import hswf_pkg::*;
#(
	parameter int POSITION_BITS = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            pose_valid,
	input  logic signed [POSITION_BITS-1:0] tip_x,
	input  logic signed [POSITION_BITS-1:0] tip_y,
	input  logic signed [POSITION_BITS-1:0] tip_z,
	input  logic signed [POSITION_BITS-1:0] center_x,
	input  logic signed [POSITION_BITS-1:0] center_y,
	input  logic signed [POSITION_BITS-1:0] center_z,
	output logic                            valid_s1,
	input  logic                            ready_s1,
	output geom_flags_t                     flags_s1,
	output logic [POSITION_BITS-1:0]        adx_s1,
	output logic [POSITION_BITS-1:0]        ady_s1,
	output logic [POSITION_BITS-1:0]        adz_s1
);

	logic signed [POSITION_BITS:0] dx, dy, dz;
	logic [POSITION_BITS:0]        neg_dx, neg_dy, neg_dz;
	logic [POSITION_BITS-1:0]      adx, ady, adz;
	logic                          load;
	logic                          v_q;

	// offsets need one extra bit; their magnitude fits back in POSITION_BITS
	assign dx = {tip_x[POSITION_BITS-1], tip_x} - {center_x[POSITION_BITS-1], center_x};
	assign dy = {tip_y[POSITION_BITS-1], tip_y} - {center_y[POSITION_BITS-1], center_y};
	assign dz = {tip_z[POSITION_BITS-1], tip_z} - {center_z[POSITION_BITS-1], center_z};

	assign neg_dx = -dx;
	assign neg_dy = -dy;
	assign neg_dz = -dz;

	assign adx = dx[POSITION_BITS] ? neg_dx[POSITION_BITS-1:0] : dx[POSITION_BITS-1:0];
	assign ady = dy[POSITION_BITS] ? neg_dy[POSITION_BITS-1:0] : dy[POSITION_BITS-1:0];
	assign adz = dz[POSITION_BITS] ? neg_dz[POSITION_BITS-1:0] : dz[POSITION_BITS-1:0];

	assign in_ready = !v_q || ready_s1;
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			flags_s1.pose_valid <= pose_valid;
			flags_s1.dy_neg     <= dy[POSITION_BITS];
			flags_s1.dy_pos     <= !dy[POSITION_BITS] && (dy != '0);
			adx_s1              <= adx;
			ady_s1              <= ady;
			adz_s1              <= adz;
		end
	end

	assign valid_s1 = v_q;

endmodule

// ===== rtl/core/hswf_force.sv =====
// Force stage: stiffness product, limit and inside tests, normal flip, result register.
`timescale 1ns / 1ps

module hswf_force
	import hswf_pkg::*;
#(
	parameter int POSITION_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         valid_s1,
	output logic                         ready_s1,
	input  geom_flags_t                  flags_s1,
	input  logic [POSITION_BITS-1:0]     adx_s1,
	input  logic [POSITION_BITS-1:0]     ady_s1,
	input  logic [POSITION_BITS-1:0]     adz_s1,
	input  logic [HALF_SIZE_W-1:0]       half_size,
	input  logic [STIFFNESS_W-1:0]       stiffness,
	input  logic [FORCE_LIMIT_W-1:0]     force_limit,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [FORCE_W-1:0]    force_normal,
	output logic                         normal_flipped
);

	localparam int PROD_W = STIFFNESS_W + POSITION_BITS;
	localparam int CMP_W  = (POSITION_BITS > HALF_SIZE_W) ? POSITION_BITS : HALF_SIZE_W;

	logic [PROD_W-1:0]        prod;
	logic [PROD_W-1:0]        limit_ext;
	logic [CMP_W-1:0]         adx_e, adz_e, half_e;
	logic                     in_square, over, pen, flip, apply;
	logic [FORCE_W-1:0]       mag_e, force_d;
	logic                     load;
	logic                     v_q;
	logic                     sign_q;
	logic [FORCE_W-1:0]       force_q;

	assign prod      = PROD_W'(stiffness) * PROD_W'(ady_s1);
	assign limit_ext = PROD_W'({force_limit, {STIFF_FRAC_W{1'b0}}});
	assign over      = prod > limit_ext;

	assign adx_e     = CMP_W'(adx_s1);
	assign adz_e     = CMP_W'(adz_s1);
	assign half_e    = CMP_W'(half_size);
	assign in_square = (adx_e < half_e) && (adz_e < half_e);

	// normal -y penetrates when dy < 0, normal +y when dy > 0
	assign pen   = flags_s1.pose_valid && (sign_q ? flags_s1.dy_pos : flags_s1.dy_neg);
	assign flip  = pen && (over || !in_square);
	assign apply = pen && !flip;

	// not over the limit, so the shifted product fits the limit width
	assign mag_e   = apply ? FORCE_W'(prod[STIFF_FRAC_W +: FORCE_LIMIT_W]) : '0;
	assign force_d = sign_q ? -mag_e : mag_e;

	assign ready_s1 = !v_q || out_ready;
	assign load     = valid_s1 && ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q    <= 1'b0;
			sign_q <= 1'b0;
		end else begin
			if (ready_s1) begin
				v_q <= valid_s1;
			end
			if (load) begin
				sign_q <= sign_q ^ flip;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			force_q <= force_d;
		end
	end

	assign out_valid      = v_q;
	assign force_normal   = signed'(force_q);
	assign normal_flipped = sign_q;

endmodule

// ===== rtl/core/haptic_square_wall_force_unit.sv =====
// Pipeline: input register then result register.
// Throughput: one item per cycle unless out_ready stalls the pipeline; the
// stiffness multiply and limit compare in the force stage set the clock period.
// Reset: config registers take their default values, the normal points
// toward -y, and both pipeline stages are empty.
`timescale 1ns / 1ps

module haptic_square_wall_force_unit
	import hswf_pkg::*;
#(
	parameter int POSITION_BITS = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [CFG_INDEX_W-1:0]          cfg_index,
	input  logic [((POSITION_BITS > FORCE_LIMIT_W) ? POSITION_BITS : FORCE_LIMIT_W)-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            pose_valid,
	input  logic signed [POSITION_BITS-1:0] tip_x,
	input  logic signed [POSITION_BITS-1:0] tip_y,
	input  logic signed [POSITION_BITS-1:0] tip_z,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [FORCE_W-1:0]       force_normal,
	output logic                            normal_flipped
);

	localparam int CFG_DATA_W = (POSITION_BITS > FORCE_LIMIT_W) ? POSITION_BITS : FORCE_LIMIT_W;

	logic [HALF_SIZE_W-1:0]          half_size;
	logic [STIFFNESS_W-1:0]          stiffness;
	logic [FORCE_LIMIT_W-1:0]        force_limit;
	logic signed [POSITION_BITS-1:0] center_x, center_y, center_z;
	logic                            valid_s1, ready_s1;
	geom_flags_t                     flags_s1;
	logic [POSITION_BITS-1:0]        adx_s1, ady_s1, adz_s1;

	hswf_cfg_regs #(
		.POSITION_BITS(POSITION_BITS),
		.CFG_DATA_W(CFG_DATA_W)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.half_size(half_size),
		.stiffness(stiffness),
		.force_limit(force_limit),
		.center_x(center_x),
		.center_y(center_y),
		.center_z(center_z)
	);

	hswf_geom #(
		.POSITION_BITS(POSITION_BITS)
	) u_geom (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pose_valid(pose_valid),
		.tip_x(tip_x),
		.tip_y(tip_y),
		.tip_z(tip_z),
		.center_x(center_x),
		.center_y(center_y),
		.center_z(center_z),
		.valid_s1(valid_s1),
		.ready_s1(ready_s1),
		.flags_s1(flags_s1),
		.adx_s1(adx_s1),
		.ady_s1(ady_s1),
		.adz_s1(adz_s1)
	);

	hswf_force #(
		.POSITION_BITS(POSITION_BITS)
	) u_force (
		.clk(clk),
		.arst_n(arst_n),
		.valid_s1(valid_s1),
		.ready_s1(ready_s1),
		.flags_s1(flags_s1),
		.adx_s1(adx_s1),
		.ady_s1(ady_s1),
		.adz_s1(adz_s1),
		.half_size(half_size),
		.stiffness(stiffness),
		.force_limit(force_limit),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.force_normal(force_normal),
		.normal_flipped(normal_flipped)
	);

endmodule

// ===== verif/tb_haptic_square_wall_force_unit.sv =====
// Testbench for the haptic square wall force unit: directed and random samples checked in order.
`timescale 1ns / 1ps

module tb_haptic_square_wall_force_unit;
	import hswf_pkg::*;

	localparam int POS_W          = 24;
	localparam int CFG_DATA_W     = (POS_W > FORCE_LIMIT_W) ? POS_W : FORCE_LIMIT_W;
	localparam int RESULT_LATENCY = 2;
	localparam int HOLD_CYCLES    = 120;
	localparam int CYCLE_LIMIT    = 200000;

	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
	localparam longint HALF_MAX  = (64'd1 << HALF_SIZE_W) - 1;
	localparam longint STIFF_MAX = (64'd1 << STIFFNESS_W) - 1;
	localparam longint LIMIT_MAX = (64'd1 << FORCE_LIMIT_W) - 1;

	typedef struct {
		logic signed [FORCE_W-1:0] normal_force;
		logic                      sign_after;
	} reaction_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_INDEX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]    cfg_data;
	logic                     in_valid;
	logic                     in_ready;
	logic                     pose_valid;
	logic signed [POS_W-1:0]  tip_x;
	logic signed [POS_W-1:0]  tip_y;
	logic signed [POS_W-1:0]  tip_z;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [FORCE_W-1:0] force_normal;
	logic                     normal_flipped;

	// predictor shadow of the block's registers and normal sign
	longint wall_half;
	longint wall_stiff;
	longint wall_limit;
	longint wall_cx;
	longint wall_cy;
	longint wall_cz;
	bit     wall_sign;

	reaction_t pending_reactions[$];
	reaction_t oldest_reaction;

	bit     in_idle_en;
	bit     out_idle_en;
	bit     hold_req;
	int     hold_count;
	longint cycle_count;
	int     mismatches;
	int     samples_sent;
	int     results_seen;
	int     forces_seen;
	int     flips_predicted;
	int     reg_writes;

	haptic_square_wall_force_unit #(
		.POSITION_BITS(POS_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pose_valid(pose_valid),
		.tip_x(tip_x),
		.tip_y(tip_y),
		.tip_z(tip_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.force_normal(force_normal),
		.normal_flipped(normal_flipped)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				pending_reactions.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic longint abs_val(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// penalty force for one sample; advances the normal sign like the block does
	function automatic reaction_t compute_wall_reaction(logic pv, logic signed [POS_W-1:0] x,
		logic signed [POS_W-1:0] y, logic signed [POS_W-1:0] z);
		longint    dx, dy, dz, depth, prod, mag;
		bit        in_square;
		reaction_t r;
		r.normal_force = '0;
		if (pv) begin
			dx = longint'(x) - wall_cx;
			dy = longint'(y) - wall_cy;
			dz = longint'(z) - wall_cz;
			depth = wall_sign ? dy : -dy;
			if (depth > 0) begin
				in_square = (abs_val(dx) < wall_half) && (abs_val(dz) < wall_half);
				prod = wall_stiff * depth;
				if (prod > (wall_limit <<< STIFF_FRAC_W) || !in_square) begin
					wall_sign = ~wall_sign;
					flips_predicted++;
				end else begin
					mag = prod >>> STIFF_FRAC_W;
					r.normal_force = FORCE_W'(wall_sign ? -mag : mag);
				end
			end
		end
		r.sign_after = wall_sign;
		return r;
	endfunction

	function automatic longint pick_between(longint lo, longint hi);
		longint span;
		span = hi - lo;
		if (span <= 0)
			return lo;
		if (span > 64'h7FFF_FFFF)
			span = 64'h7FFF_FFFF;
		return lo + longint'($urandom_range(32'(span), 0));
	endfunction

	// tip y that gives the wanted penetration along the current normal
	function automatic logic signed [POS_W-1:0] depth_to_tip_y(longint depth);
		return POS_W'(wall_cy + (wall_sign ? depth : -depth));
	endfunction

	// register word with junk above the field width
	function automatic logic [CFG_DATA_W-1:0] field_word(longint v, int w);
		logic [CFG_DATA_W-1:0] d, mask;
		d = CFG_DATA_W'($urandom);
		mask = CFG_DATA_W'((64'd1 << w) - 1);
		return (d & ~mask) | (CFG_DATA_W'(v) & mask);
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
		mismatches++;
	endtask

	// leaves cfg_valid high; the caller lowers it after the last write
	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		reg_writes++;
		case (idx)
			REG_HALF_SIZE:   wall_half  = longint'(d[HALF_SIZE_W-1:0]);
			REG_STIFFNESS:   wall_stiff = longint'(d[STIFFNESS_W-1:0]);
			REG_FORCE_LIMIT: wall_limit = longint'(d[FORCE_LIMIT_W-1:0]);
			REG_CENTER_X:    wall_cx    = longint'($signed(d[POS_W-1:0]));
			REG_CENTER_Y:    wall_cy    = longint'($signed(d[POS_W-1:0]));
			REG_CENTER_Z:    wall_cz    = longint'($signed(d[POS_W-1:0]));
			default: ;
		endcase
	endtask

	task automatic set_wall(longint h, longint k, longint l, longint cx, longint cy, longint cz);
		write_reg(REG_HALF_SIZE, field_word(h, HALF_SIZE_W));
		write_reg(REG_STIFFNESS, field_word(k, STIFFNESS_W));
		write_reg(REG_FORCE_LIMIT, field_word(l, FORCE_LIMIT_W));
		write_reg(REG_CENTER_X, field_word(cx, POS_W));
		write_reg(REG_CENTER_Y, field_word(cy, POS_W));
		write_reg(REG_CENTER_Z, field_word(cz, POS_W));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_sample(logic pv, logic signed [POS_W-1:0] x,
		logic signed [POS_W-1:0] y, logic signed [POS_W-1:0] z);
		if (in_idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		pose_valid <= pv;
		tip_x      <= x;
		tip_y      <= y;
		tip_z      <= z;
		do @(posedge clk); while (!in_ready);
		pending_reactions.push_back(compute_wall_reaction(pv, x, y, z));
		samples_sent++;
	endtask

	task automatic send_random(bit well_formed);
		longint reach, pmax, depth;
		if (well_formed) begin
			reach = wall_half + wall_half / 8 + 2;
			pmax = (wall_stiff == 0) ? 4096 : ((wall_limit << STIFF_FRAC_W) / wall_stiff + 1);
			if (pmax > (64'd1 << 23))
				pmax = 64'd1 << 23;
			depth = pick_between(-pmax / 4 - 1, pmax + pmax / 4 + 1);
			send_sample($urandom_range(0, 15) != 0,
				POS_W'(wall_cx + pick_between(-reach, reach)),
				depth_to_tip_y(depth),
				POS_W'(wall_cz + pick_between(-reach, reach)));
		end else begin
			send_sample(1'($urandom_range(0, 1)), POS_W'($urandom), POS_W'($urandom),
				POS_W'($urandom));
		end
	endtask

	task automatic pick_random_wall();
		longint h, k, l, c[3];
		case ($urandom_range(0, 9))
			0:       h = 0;
			1:       h = HALF_MAX;
			default: h = pick_between(1, 200000);
		endcase
		case ($urandom_range(0, 9))
			0:       k = 0;
			1:       k = STIFF_MAX;
			2:       k = 256;
			default: k = pick_between(1, 1 << 18);
		endcase
		case ($urandom_range(0, 9))
			0:       l = 0;
			1:       l = LIMIT_MAX;
			default: l = pick_between(1, 1 << 24);
		endcase
		foreach (c[i]) begin
			case ($urandom_range(0, 9))
				0:       c[i] = longint'(POS_MIN);
				1:       c[i] = longint'(POS_MAX);
				2, 3:    c[i] = longint'($signed(POS_W'($urandom)));
				default: c[i] = pick_between(-100000, 100000);
			endcase
		end
		set_wall(h, k, l, c[0], c[1], c[2]);
	endtask

	// sender stops until every expected result is back and the pipe is empty
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_reactions.size() != 0) @(posedge clk);
		repeat (RESULT_LATENCY + 2) @(posedge clk);
	endtask

	task automatic test_directed_defaults();
		send_sample(1'b0, POS_MAX, POS_MIN, POS_MAX);
		send_sample(1'b0, 0, -1000, 0);
		send_sample(1'b1, 0, 0, 0);
		send_sample(1'b1, 100, 5000, -100);
		send_sample(1'b1, 0, -1000, 0);
		// force lands exactly on the limit, then one step past it
		send_sample(1'b1, 49999, -20000, -49999);
		send_sample(1'b1, 0, -20001, 0);
		send_sample(1'b1, 0, 1000, 0);
		send_sample(1'b1, 0, -1000, 0);
		// edge of the square is outside
		send_sample(1'b1, 50000, depth_to_tip_y(10), 0);
		send_sample(1'b1, 0, depth_to_tip_y(10), -50000);
		send_sample(1'b1, -49999, depth_to_tip_y(10), 49999);
		send_sample(1'b1, POS_MIN, POS_MAX, POS_MIN);
		send_sample(1'b1, POS_MAX, POS_MIN, POS_MAX);
	endtask

	task automatic test_config_extremes();
		settle();
		set_wall(0, 64000, 5000000, 0, 0, 0);
		send_sample(1'b1, 0, depth_to_tip_y(1), 0);
		send_sample(1'b1, 0, depth_to_tip_y(1), 0);
		settle();
		set_wall(HALF_MAX, 0, LIMIT_MAX, 0, 0, 0);
		send_sample(1'b1, 0, depth_to_tip_y(5000), 0);
		send_sample(1'b1, POS_MAX, depth_to_tip_y(5000), 0);
		settle();
		set_wall(HALF_MAX, STIFF_MAX, 0, 0, 0, 0);
		send_sample(1'b1, 0, depth_to_tip_y(1), 0);
		settle();
		set_wall(HALF_MAX, STIFF_MAX, LIMIT_MAX, 0, 0, 0);
		send_sample(1'b1, 0, depth_to_tip_y(1024), 0);
		send_sample(1'b1, 0, depth_to_tip_y(1025), 0);
		send_sample(1'b1, 0, depth_to_tip_y(1024), 0);
		settle();
		set_wall(1000, 256, 1000, longint'(POS_MAX), longint'(POS_MIN), longint'(POS_MAX));
		send_sample(1'b1, POS_MAX, POS_W'(POS_MIN + 500), POS_MAX);
		send_sample(1'b1, POS_MIN, POS_MAX, POS_MIN);
		send_sample(1'b1, POS_MAX, POS_W'(POS_MIN + 500), POS_MAX);
	endtask

	task automatic test_spare_registers();
		settle();
		write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
		write_reg(REG_SPARE_HI, '1);
		cfg_valid <= 1'b0;
		repeat (4) send_random(1'b1);
	endtask

	task automatic test_backpressure();
		settle();
		set_wall(50000, 64000, 5000000, 0, 0, 0);
		in_idle_en  = 1'b0;
		out_idle_en = 1'b0;
		hold_req    = 1'b1;
		repeat (40) send_random(1'b1);
	endtask

	task automatic test_random_walls();
		for (int p = 0; p < 8; p++) begin
			settle();
			pick_random_wall();
			in_idle_en  = (p % 3 != 2);
			out_idle_en = (p % 3 != 1);
			repeat (70) send_random($urandom_range(0, 3) != 0);
		end
	endtask

	task automatic test_final_streaming();
		settle();
		pick_random_wall();
		in_idle_en  = 1'b0;
		out_idle_en = 1'b0;
		repeat (100) send_random($urandom_range(0, 3) != 0);
	endtask

	// receiver: random stall bursts, plus one long hold requested by the backpressure test
	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
					@(posedge clk);
				hold_req = 1'b0;
			end else if (out_idle_en && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 10)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : result_check
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_reactions.size() == 0) begin
				report_mismatch("unexpected result, force_normal", force_normal, 0);
			end else begin
				oldest_reaction = pending_reactions.pop_front();
				if (oldest_reaction.normal_force != 0)
					forces_seen++;
				if (force_normal !== oldest_reaction.normal_force)
					report_mismatch("force_normal", force_normal, oldest_reaction.normal_force);
				if (normal_flipped !== oldest_reaction.sign_after)
					report_mismatch("normal_flipped", normal_flipped,
						oldest_reaction.sign_after);
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		pose_valid  = 1'b0;
		tip_x       = '0;
		tip_y       = '0;
		tip_z       = '0;
		in_idle_en  = 1'b0;
		out_idle_en = 1'b0;
		hold_req    = 1'b0;
		wall_half   = longint'(HALF_SIZE_RST);
		wall_stiff  = longint'(STIFFNESS_RST);
		wall_limit  = longint'(FORCE_LIMIT_RST);
		wall_cx     = 0;
		wall_cy     = 0;
		wall_cz     = 0;
		wall_sign   = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_defaults();
		test_config_extremes();
		test_spare_registers();
		test_backpressure();
		test_random_walls();
		test_final_streaming();

		settle();
		repeat (8) @(posedge clk);
		$display("Covered %0d samples over several wall settings: %0d with force, %0d flips,",
			samples_sent, forces_seen, flips_predicted);
		$display("%0d register writes, %0d results checked, %0d mismatches", reg_writes,
			results_seen, mismatches);
		if (mismatches == 0 && pending_reactions.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
